// ----- hdl/lig_pkg.sv -----
`default_nettype none
package lig_pkg;

    localparam int MAX_LANES = 32;
    localparam int LANE_W    = $clog2(MAX_LANES);
    localparam int CNT_W     = LANE_W + 1;

    localparam int SIZE_W    = 11;
    localparam int XY_W      = 10;
    localparam int Z_W       = 11;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;

    localparam logic [SIZE_W-1:0] SIZE_LIMIT = 11'd1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIMD_MODE = 2'd2;

    // simd modes
    localparam logic [MODE_W-1:0] SIMD8  = 2'd0;
    localparam logic [MODE_W-1:0] SIMD16 = 2'd1;

    // controller to datapath
    typedef struct packed {
        logic              walk_clr;
        logic              load_lane;
        logic              load_step;
        logic              emit;
        logic              last;
        logic [LANE_W-1:0] idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic              slot_free;
        logic [LANE_W-1:0] last_idx;
    } t_sts;

endpackage
`default_nettype wire

// ----- hdl/lig_in_if.sv -----
`default_nettype none
interface lig_in_if;
    logic valid;
    logic ready;
    logic first_of_group;

    modport source (output valid, output first_of_group, input ready);
    modport sink   (input valid, input first_of_group, output ready);
endinterface
`default_nettype wire

// ----- hdl/lig_out_if.sv -----
`default_nettype none
interface lig_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  lane;
    logic [9:0]  local_x;
    logic [9:0]  local_y;
    logic [10:0] local_z;
    logic        last;

    modport source (output valid, output lane, output local_x, output local_y,
                    output local_z, output last, input ready);
    modport sink   (input valid, input lane, input local_x, input local_y,
                    input local_z, input last, output ready);
endinterface
`default_nettype wire

// ----- hdl/lig_ctrl.sv -----
`default_nettype none
module lig_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_first,
    output logic               o_ready,
    output lig_pkg::t_cmd      o_cmd,
    input  wire lig_pkg::t_sts i_sts
);
    import lig_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_INIT, S_EMIT} t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] lane_cnt;
    logic             walk_done;
    logic             emit_last;

    assign lane_cnt  = {1'b0, i_sts.last_idx} + CNT_W'(1);
    assign walk_done = (r_cnt == lane_cnt);
    assign emit_last = (r_cnt[LANE_W-1:0] == i_sts.last_idx);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.idx = r_cnt[LANE_W-1:0];
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                n_cnt   = '0;
                if (i_valid) begin
                    if (i_first) begin
                        o_cmd.walk_clr = 1'b1;
                        n_state = S_INIT;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_INIT: begin
                // one linear index per cycle, index n gives the thread step
                o_cmd.load_lane = !walk_done;
                o_cmd.load_step = walk_done;
                if (walk_done) begin
                    n_state = S_EMIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = emit_last;
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.slot_free)
        else $error("emit into a full output slot");

    a_load_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load_lane && o_cmd.load_step))
        else $error("lane and step loaded together");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("no return to idle after last lane");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (!r_cnt[CNT_W-1] && r_cnt[LANE_W-1:0] <= i_sts.last_idx))
        else $error("lane counter past lane count");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> (r_cnt <= lane_cnt))
        else $error("walk counter past lane count");

endmodule
`default_nettype wire

// ----- hdl/lig_dp.sv -----
`default_nettype none
module lig_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [lig_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lig_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire lig_pkg::t_cmd               i_cmd,
    output lig_pkg::t_sts                    o_sts,
    input  wire logic                        i_ready,
    output logic                             o_valid,
    output logic [lig_pkg::LANE_W-1:0]       o_lane,
    output logic [lig_pkg::XY_W-1:0]         o_local_x,
    output logic [lig_pkg::XY_W-1:0]         o_local_y,
    output logic [lig_pkg::Z_W-1:0]          o_local_z,
    output logic                             o_last
);
    import lig_pkg::*;

    localparam int LANE8  = (MAX_LANES < 8)  ? MAX_LANES : 8;
    localparam int LANE16 = (MAX_LANES < 16) ? MAX_LANES : 16;

    logic [SIZE_W-1:0] r_size_x, r_size_y;
    logic [MODE_W-1:0] r_mode;

    logic [XY_W-1:0] r_lane_x [MAX_LANES];
    logic [XY_W-1:0] r_lane_y [MAX_LANES];
    logic [Z_W-1:0]  r_lane_z [MAX_LANES];
    logic [XY_W-1:0] r_step_x, r_step_y;
    logic [Z_W-1:0]  r_step_z;

    logic [XY_W-1:0] r_wx, r_wy, n_wx, n_wy;
    logic [Z_W-1:0]  r_wz, n_wz;

    logic [SIZE_W-1:0] sx, sy;
    logic [SIZE_W-1:0] wx1, wy1;
    logic [SIZE_W-1:0] ax, ay, fx, fy;
    logic              cx, cy;
    logic [Z_W-1:0]    nz;
    logic [XY_W-1:0]   cur_x, cur_y;
    logic [Z_W-1:0]    cur_z;

    // effective sizes, zero means one, clamp at the limit
    assign sx = (r_size_x == '0) ? SIZE_W'(1) :
                (r_size_x > SIZE_LIMIT) ? SIZE_LIMIT : r_size_x;
    assign sy = (r_size_y == '0) ? SIZE_W'(1) :
                (r_size_y > SIZE_LIMIT) ? SIZE_LIMIT : r_size_y;

    always_comb begin
        o_sts.slot_free = !o_valid || i_ready;
        case (r_mode)
            SIMD8:   o_sts.last_idx = LANE_W'(LANE8 - 1);
            SIMD16:  o_sts.last_idx = LANE_W'(LANE16 - 1);
            default: o_sts.last_idx = LANE_W'(MAX_LANES - 1);
        endcase
    end

    // mixed-radix walk over linear index
    always_comb begin
        wx1  = {1'b0, r_wx} + SIZE_W'(1);
        wy1  = {1'b0, r_wy} + SIZE_W'(1);
        n_wx = wx1[XY_W-1:0];
        n_wy = r_wy;
        n_wz = r_wz;
        if (wx1 == sx) begin
            n_wx = '0;
            n_wy = wy1[XY_W-1:0];
            if (wy1 == sy) begin
                n_wy = '0;
                n_wz = r_wz + Z_W'(1);
            end
        end
    end

    // per-lane advance by one thread
    assign cur_x = r_lane_x[i_cmd.idx];
    assign cur_y = r_lane_y[i_cmd.idx];
    assign cur_z = r_lane_z[i_cmd.idx];

    always_comb begin
        ax = {1'b0, cur_x} + {1'b0, r_step_x};
        cx = (ax >= sx);
        fx = cx ? (ax - sx) : ax;
        ay = {1'b0, cur_y} + {1'b0, r_step_y} + SIZE_W'(cx);
        cy = (ay >= sy);
        fy = cy ? (ay - sy) : ay;
        nz = cur_z + r_step_z + Z_W'(cy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_W'(1);
            r_size_y <= SIZE_W'(1);
            r_mode   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE_X:    r_size_x <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:    r_size_y <= i_cfg_data[SIZE_W-1:0];
                CFG_SIMD_MODE: r_mode   <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LANES; i++) begin
                r_lane_x[i] <= '0;
                r_lane_y[i] <= '0;
                r_lane_z[i] <= '0;
            end
            r_step_x <= '0;
            r_step_y <= '0;
            r_step_z <= '0;
        end else begin
            if (i_cmd.load_lane) begin
                r_lane_x[i_cmd.idx] <= r_wx;
                r_lane_y[i_cmd.idx] <= r_wy;
                r_lane_z[i_cmd.idx] <= r_wz;
            end else if (i_cmd.emit) begin
                r_lane_x[i_cmd.idx] <= fx[XY_W-1:0];
                r_lane_y[i_cmd.idx] <= fy[XY_W-1:0];
                r_lane_z[i_cmd.idx] <= nz;
            end
            if (i_cmd.load_step) begin
                r_step_x <= r_wx;
                r_step_y <= r_wy;
                r_step_z <= r_wz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_clr) begin
            r_wx <= '0;
            r_wy <= '0;
            r_wz <= '0;
        end else if (i_cmd.load_lane) begin
            r_wx <= n_wx;
            r_wy <= n_wy;
            r_wz <= n_wz;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_lane    <= i_cmd.idx;
            o_local_x <= cur_x;
            o_local_y <= cur_y;
            o_local_z <= cur_z;
            o_last    <= i_cmd.last;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/local_id_generator_core.sv -----
// channel   dir  payload                                      handshake
// i_item    in   first_of_group                               valid/ready
// o_result  out  lane, local_x, local_y, local_z, last         valid/ready
// cfg       in   i_cfg_idx, i_cfg_data                        i_cfg_we, no wait
//
// n lanes per thread (8, 16 or 32). a group start walks the linear index one
// per cycle to load the lanes and then the step, then emits the n lanes; a
// later thread only emits its n lanes
// reset is synchronous, active low, and clears lane coordinates and steps
// output stalls hold the emit loop; the output register lets a new item in
// while the last lane of the previous thread still waits
`default_nettype none
module local_id_generator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lig_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lig_pkg::CFG_W-1:0]     i_cfg_data,
    lig_in_if.sink                             i_item,
    lig_out_if.source                          o_result
);
    import lig_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: walk on a group start, then emit lane by lane
    lig_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_first (i_item.first_of_group),
        .o_ready (i_item.ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // config, lane coordinate store, advance adders, output register
    lig_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_ready    (o_result.ready),
        .o_valid    (o_result.valid),
        .o_lane     (o_result.lane),
        .o_local_x  (o_result.local_x),
        .o_local_y  (o_result.local_y),
        .o_local_z  (o_result.local_z),
        .o_last     (o_result.last)
    );

endmodule
`default_nettype wire
